FILE: rtl/gbre_pkg.sv
// Package for the glyph bitmap run extractor.
// Holds the channel payload types, the internal hand-off structs and the register codes.
package gbre_pkg;

	localparam logic [9:0] SCREEN_MAX = 10'd512;
	localparam logic [9:0] SCREEN_WIDTH_RESET = 10'd240;
	localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd320;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic               glyph_start;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [7:0]         glyph_width;
		logic [7:0]         glyph_height;
		logic signed [7:0]  offset_x;
		logic signed [7:0]  offset_y;
		logic [15:0]        ink_colour;
		logic [7:0]         bitmap_byte;
	} glyph_item_t;

	typedef struct packed {
		logic [8:0]  run_x;
		logic [8:0]  run_y;
		logic [7:0]  run_length;
		logic [15:0] swapped_colour;
		logic        last_run;
	} run_item_t;

	// Queue head as seen by the walker; coordinates travel beside it.
	typedef struct packed {
		logic        start;
		logic [7:0]  width;
		logic [7:0]  height;
		logic [15:0] colour;
		logic [7:0]  bits;
	} head_t;

	// One walker step: an optional closed run and the end-of-byte mark.
	typedef struct packed {
		logic        emit;
		logic        byte_end;
		logic [7:0]  len;
		logic [15:0] colour;
	} evt_t;

endpackage

FILE: rtl/glyph_bitmap_run_extractor.sv
// Top level of the glyph bitmap run extractor: screen size registers, front queue,
// bit walker and result stage. Uses gbre_pkg, gbre_front, gbre_walker and gbre_emit.
//
// Each input transaction carries one byte of a packed 1-bit glyph bitmap; the bit walker
// steps through it one bitmap bit per cycle while the result stage does not halt it,
// whether or not the bit lies inside the glyph. A two-entry queue in front keeps taking
// transactions while the walker is busy until it is full; the walker and result stage
// halt together only when a finished run cannot leave the output register. A run closed
// by a bit in the middle of a byte waits in the pending register until another on-screen
// run of the same byte closes, or until the byte's last bit, and then moves to the output
// register; a run closed by the last bit of a byte moves on from the pending register
// without waiting. Output stalls can hold either back. Screen width and height reset to
// 240 and 320, values above 512 act as 512, and register writes are taken at any time
// with ready held high, but belong only to idle periods.
module glyph_bitmap_run_extractor #(
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   glyph_valid,
	output logic                   glyph_stall,
	input  gbre_pkg::glyph_item_t  glyph,
	output logic                   run_valid,
	input  logic                   run_stall,
	output gbre_pkg::run_item_t    run,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [9:0]             cfg_data
);
	import gbre_pkg::*;

	logic [9:0]            scr_w_q;
	logic [9:0]            scr_h_q;
	logic [9:0]            scr_w;
	logic [9:0]            scr_h;
	logic                  head_valid;
	head_t                 head;
	logic [COORD_BITS-1:0] head_base_x;
	logic [COORD_BITS-1:0] head_base_y;
	logic                  head_pop;
	logic                  hold;
	evt_t                  evt_s1;
	logic [COORD_BITS-1:0] px_s1;
	logic [COORD_BITS-1:0] py_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_WIDTH_RESET;
			scr_h_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: scr_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: scr_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign scr_w = (scr_w_q > SCREEN_MAX) ? SCREEN_MAX : scr_w_q;
	assign scr_h = (scr_h_q > SCREEN_MAX) ? SCREEN_MAX : scr_h_q;

	gbre_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph       (glyph),
		.head_valid  (head_valid),
		.head        (head),
		.head_base_x (head_base_x),
		.head_base_y (head_base_y),
		.head_pop    (head_pop)
	);

	gbre_walker #(
		.COORD_BITS(COORD_BITS)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.head_base_x (head_base_x),
		.head_base_y (head_base_y),
		.head_pop    (head_pop),
		.hold        (hold),
		.evt_s1      (evt_s1),
		.px_s1       (px_s1),
		.py_s1       (py_s1)
	);

	gbre_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_s1    (evt_s1),
		.px_s1     (px_s1),
		.py_s1     (py_s1),
		.scr_w     (scr_w),
		.scr_h     (scr_h),
		.hold      (hold),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.run       (run)
	);

endmodule

FILE: rtl/gbre_front.sv
// Front end of the glyph bitmap run extractor: accepts input transactions,
// precomputes the glyph base position and swapped colour, and queues them. Uses gbre_pkg.
module gbre_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    glyph_valid,
	output logic                    glyph_stall,
	input  gbre_pkg::glyph_item_t   glyph,
	output logic                    head_valid,
	output gbre_pkg::head_t         head,
	output logic [COORD_BITS-1:0]   head_base_x,
	output logic [COORD_BITS-1:0]   head_base_y,
	input  logic                    head_pop
);
	import gbre_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		head_t                 info;
		logic [COORD_BITS-1:0] base_x;
		logic [COORD_BITS-1:0] base_y;
	} entry_t;

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	logic [15:0]      sum_x;
	logic [15:0]      sum_y;
	entry_t           new_entry;

	assign glyph_stall = (count_q == CNT_W'(DEPTH));
	assign push = glyph_valid && !glyph_stall;
	assign head_valid = (count_q != '0);
	assign pop = head_pop && head_valid;

	// Base position is origin plus sign-extended offset, wrapped to the coordinate width.
	assign sum_x = glyph.origin_x + {{8{glyph.offset_x[7]}}, glyph.offset_x};
	assign sum_y = glyph.origin_y + {{8{glyph.offset_y[7]}}, glyph.offset_y};

	always_comb begin
		new_entry.info.start = glyph.glyph_start;
		new_entry.info.width = glyph.glyph_width;
		new_entry.info.height = glyph.glyph_height;
		new_entry.info.colour = {glyph.ink_colour[7:0], glyph.ink_colour[15:8]};
		new_entry.info.bits = glyph.bitmap_byte;
		new_entry.base_x = sum_x[COORD_BITS-1:0];
		new_entry.base_y = sum_y[COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head = mem_q[rd_ptr_q].info;
	assign head_base_x = mem_q[rd_ptr_q].base_x;
	assign head_base_y = mem_q[rd_ptr_q].base_y;

endmodule

FILE: rtl/gbre_walker.sv
// Bit walker of the glyph bitmap run extractor: steps one bitmap bit per cycle unless
// held, tracks row, column and the open run, and registers closed runs. Uses gbre_pkg.
module gbre_walker #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  gbre_pkg::head_t         head,
	input  logic [COORD_BITS-1:0]   head_base_x,
	input  logic [COORD_BITS-1:0]   head_base_y,
	output logic                    head_pop,
	input  logic                    hold,
	output gbre_pkg::evt_t          evt_s1,
	output logic [COORD_BITS-1:0]   px_s1,
	output logic [COORD_BITS-1:0]   py_s1
);
	import gbre_pkg::*;

	logic [COORD_BITS-1:0] base_x_q;
	logic [COORD_BITS-1:0] base_y_q;
	logic [7:0]            width_q;
	logic [7:0]            height_q;
	logic [15:0]           colour_q;
	logic [7:0]            row_q;
	logic [7:0]            col_q;
	logic [7:0]            len_q;
	logic [7:0]            start_q;
	logic [2:0]            bit_q;

	logic                  take_new;
	logic                  step;
	logic [COORD_BITS-1:0] eff_bx;
	logic [COORD_BITS-1:0] eff_by;
	logic [7:0]            eff_w;
	logic [7:0]            eff_h;
	logic [15:0]           eff_colour;
	logic [7:0]            row0;
	logic [7:0]            col0;
	logic [7:0]            len0;
	logic [7:0]            st0;
	logic [7:0]            row1;
	logic [7:0]            col1;
	logic [7:0]            len1;
	logic [7:0]            st1;
	logic                  active;
	logic                  cur_bit;
	logic                  emit;
	logic [7:0]            emit_start;
	logic [7:0]            emit_len;

	// A start transaction replaces the glyph fields before its first bit is walked.
	assign take_new = head.start && (bit_q == 3'd0);
	assign step = head_valid && !hold;
	assign head_pop = step && (bit_q == 3'd7);

	always_comb begin
		eff_bx = take_new ? head_base_x : base_x_q;
		eff_by = take_new ? head_base_y : base_y_q;
		eff_w = take_new ? head.width : width_q;
		eff_h = take_new ? head.height : height_q;
		eff_colour = take_new ? head.colour : colour_q;
		row0 = take_new ? 8'd0 : row_q;
		col0 = take_new ? 8'd0 : col_q;
		len0 = take_new ? 8'd0 : len_q;
		st0 = take_new ? 8'd0 : start_q;
	end

	assign active = (eff_w != 8'd0) && (row0 < eff_h);
	assign cur_bit = head.bits[~bit_q];

	always_comb begin
		row1 = row0;
		col1 = col0;
		len1 = len0;
		st1 = st0;
		emit = 1'b0;
		emit_start = st0;
		emit_len = len0;
		if (active) begin
			if (cur_bit) begin
				if (len0 == 8'd0) begin
					st1 = col0;
				end
				len1 = len0 + 8'd1;
			end else if (len0 != 8'd0) begin
				emit = 1'b1;
				len1 = 8'd0;
			end
			col1 = col0 + 8'd1;
			// At the end of a glyph row any open run closes and the walk moves down.
			if (col1 >= eff_w) begin
				if (len1 != 8'd0) begin
					emit = 1'b1;
					emit_start = st1;
					emit_len = len1;
				end
				len1 = 8'd0;
				col1 = 8'd0;
				row1 = row0 + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			height_q <= '0;
			row_q <= '0;
			col_q <= '0;
			len_q <= '0;
			start_q <= '0;
			bit_q <= '0;
			evt_s1 <= '0;
		end else if (!hold) begin
			if (head_valid) begin
				width_q <= eff_w;
				height_q <= eff_h;
				row_q <= row1;
				col_q <= col1;
				len_q <= len1;
				start_q <= st1;
				bit_q <= bit_q + 3'd1;
				evt_s1.emit <= emit;
				evt_s1.byte_end <= (bit_q == 3'd7);
				evt_s1.len <= emit_len;
				evt_s1.colour <= eff_colour;
			end else begin
				evt_s1.emit <= 1'b0;
				evt_s1.byte_end <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			base_x_q <= eff_bx;
			base_y_q <= eff_by;
			colour_q <= eff_colour;
			px_s1 <= eff_bx + COORD_BITS'(emit_start);
			py_s1 <= eff_by + COORD_BITS'(row0);
		end
	end

endmodule

FILE: rtl/gbre_emit.sv
// Result stage of the glyph bitmap run extractor: drops and clips runs against the screen,
// holds one run back to mark the last run of each byte, and drives the output register. Uses gbre_pkg.
module gbre_emit #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gbre_pkg::evt_t          evt_s1,
	input  logic [COORD_BITS-1:0]   px_s1,
	input  logic [COORD_BITS-1:0]   py_s1,
	input  logic [9:0]              scr_w,
	input  logic [9:0]              scr_h,
	output logic                    hold,
	output logic                    run_valid,
	input  logic                    run_stall,
	output gbre_pkg::run_item_t     run
);
	import gbre_pkg::*;

	logic        keep;
	logic [9:0]  end_x;
	logic [7:0]  clip_len;
	run_item_t   new_run;
	logic        pend_valid_q;
	logic        pend_sealed_q;
	run_item_t   pend_q;
	run_item_t   out_run;
	logic        push;
	logic        out_free;
	logic        run_valid_q;
	run_item_t   run_q;

	assign keep = evt_s1.emit && !px_s1[COORD_BITS-1] && !py_s1[COORD_BITS-1]
		&& (px_s1 < COORD_BITS'(scr_w)) && (py_s1 < COORD_BITS'(scr_h));

	// A kept run starts on screen, so its column fits in nine bits.
	assign end_x = {1'b0, px_s1[8:0]} + {2'b00, evt_s1.len};
	always_comb begin
		if (end_x > scr_w) begin
			clip_len = 8'(scr_w - {1'b0, px_s1[8:0]});
		end else begin
			clip_len = evt_s1.len;
		end
		new_run.run_x = px_s1[8:0];
		new_run.run_y = py_s1[8:0];
		new_run.run_length = clip_len;
		new_run.swapped_colour = evt_s1.colour;
		new_run.last_run = 1'b0;
	end

	always_comb begin
		out_run = pend_q;
		out_run.last_run = pend_sealed_q || (evt_s1.byte_end && !keep);
	end

	// The pending run leaves once a newer run arrives or its byte is known to be finished.
	assign push = pend_valid_q && (pend_sealed_q || keep || evt_s1.byte_end);
	assign out_free = !run_valid_q || !run_stall;
	assign hold = push && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_sealed_q <= 1'b0;
			run_valid_q <= 1'b0;
		end else if (!hold) begin
			if (keep) begin
				pend_valid_q <= 1'b1;
				pend_sealed_q <= evt_s1.byte_end;
			end else if (push) begin
				pend_valid_q <= 1'b0;
				pend_sealed_q <= 1'b0;
			end
			if (push) begin
				run_valid_q <= 1'b1;
			end else if (out_free) begin
				run_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			if (keep) begin
				pend_q <= new_run;
			end
			if (push) begin
				run_q <= out_run;
			end
		end
	end

	assign run_valid = run_valid_q;
	assign run = run_q;

endmodule

FILE: tb/glyph_bitmap_run_extractor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_bitmap_run_extractor.
// Depends on gbre_pkg for the payload structs and register codes.
module glyph_bitmap_run_extractor_tb;
	import gbre_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 60;
	localparam logic [1:0] CFG_INDEX_SPARE2 = 2'd2;
	localparam logic [1:0] CFG_INDEX_SPARE3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic glyph_valid = 1'b0;
	logic glyph_stall;
	glyph_item_t glyph = '0;
	logic run_valid;
	logic run_stall = 1'b0;
	run_item_t run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [9:0] cfg_data = '0;

	// Shadow of the block's registers and walk state.
	logic [9:0] scr_w = SCREEN_WIDTH_RESET;
	logic [9:0] scr_h = SCREEN_HEIGHT_RESET;
	logic [15:0] cur_x = '0;
	logic [15:0] cur_y = '0;
	logic [7:0] cur_w = '0;
	logic [7:0] cur_h = '0;
	logic [7:0] cur_offx = '0;
	logic [7:0] cur_offy = '0;
	logic [15:0] cur_colour = '0;
	logic [7:0] row_at = '0;
	logic [7:0] col_at = '0;
	logic [7:0] span_len = '0;
	logic [7:0] span_start = '0;

	run_item_t expected_runs[$];
	run_item_t want;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic sender_idles = 1'b1;
	logic stall_random = 1'b1;
	int hold_asks = 0;
	int hold_taken = 0;
	int hold_left = 0;

	glyph_bitmap_run_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.glyph(glyph),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run(run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Places the open span on screen; returns 0 when the span is dropped.
	function automatic bit place_span(output run_item_t r);
		int sum_x, sum_y, px, py, sw, sh, len;
		sw = (scr_w > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_w);
		sh = (scr_h > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_h);
		sum_x = $signed(cur_x) + $signed(cur_offx) + int'(span_start);
		sum_y = $signed(cur_y) + $signed(cur_offy) + int'(row_at);
		px = sum_x & 32'hFFFF;
		py = sum_y & 32'hFFFF;
		r = '0;
		if (px >= 32'h8000 || py >= 32'h8000 || px >= sw || py >= sh)
			return 1'b0;
		len = span_len;
		if (px + len > sw)
			len = sw - px;
		r.run_x = px[8:0];
		r.run_y = py[8:0];
		r.run_length = len[7:0];
		r.swapped_colour = {cur_colour[7:0], cur_colour[15:8]};
		r.last_run = 1'b0;
		return 1'b1;
	endfunction

	// Walks one bitmap byte and queues the runs it closes.
	function automatic void predict_runs(input glyph_item_t g);
		run_item_t r, held;
		bit have_held;
		have_held = 1'b0;
		held = '0;
		if (g.glyph_start) begin
			cur_x = g.origin_x;
			cur_y = g.origin_y;
			cur_w = g.glyph_width;
			cur_h = g.glyph_height;
			cur_offx = g.offset_x;
			cur_offy = g.offset_y;
			cur_colour = g.ink_colour;
			row_at = '0;
			col_at = '0;
			span_len = '0;
			span_start = '0;
		end
		for (int b = 7; b >= 0; b--) begin
			if (cur_w == 0 || row_at >= cur_h)
				break;
			if (g.bitmap_byte[b]) begin
				if (span_len == 0)
					span_start = col_at;
				span_len = span_len + 8'd1;
			end else if (span_len > 0) begin
				if (place_span(r)) begin
					if (have_held)
						expected_runs.push_back(held);
					held = r;
					have_held = 1'b1;
				end
				span_len = '0;
			end
			col_at = col_at + 8'd1;
			if (col_at >= cur_w) begin
				if (span_len > 0 && place_span(r)) begin
					if (have_held)
						expected_runs.push_back(held);
					held = r;
					have_held = 1'b1;
				end
				span_len = '0;
				col_at = '0;
				row_at = row_at + 8'd1;
			end
		end
		if (have_held) begin
			held.last_run = 1'b1;
			expected_runs.push_back(held);
		end
	endfunction

	function automatic glyph_item_t random_item();
		logic [95:0] raw;
		glyph_item_t g;
		raw = {$urandom, $urandom, $urandom};
		g = raw[$bits(glyph_item_t)-1:0];
		return g;
	endfunction

	// A bitmap byte of a glyph already started; the other fields carry junk.
	function automatic glyph_item_t filler_item(input logic [7:0] bits);
		glyph_item_t g;
		g = random_item();
		g.glyph_start = 1'b0;
		g.bitmap_byte = bits;
		return g;
	endfunction

	function automatic glyph_item_t glyph_head(input int ox, input int oy, input int w,
			input int h, input int offx, input int offy, input int colour, input int bits);
		glyph_item_t g;
		g.glyph_start = 1'b1;
		g.origin_x = ox[15:0];
		g.origin_y = oy[15:0];
		g.glyph_width = w[7:0];
		g.glyph_height = h[7:0];
		g.offset_x = offx[7:0];
		g.offset_y = offy[7:0];
		g.ink_colour = colour[15:0];
		g.bitmap_byte = bits[7:0];
		return g;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_glyph(input glyph_item_t g);
		while (sender_idles && $urandom_range(99) < 31) begin
			glyph_valid <= 1'b0;
			@(posedge clk);
		end
		glyph_valid <= 1'b1;
		glyph <= g;
		@(negedge clk);
		while (glyph_stall)
			@(negedge clk);
		@(posedge clk);
		predict_runs(g);
	endtask

	task automatic send_bitmap(input glyph_item_t head, input int nbytes);
		send_glyph(head);
		for (int i = 1; i < nbytes; i++)
			send_glyph(filler_item(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom)));
	endtask

	// Waits for every queued run, then lets byte-only work finish inside the block.
	task automatic settle_block();
		glyph_valid <= 1'b0;
		while (expected_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		if (idx == REG_SCREEN_WIDTH)
			scr_w = value;
		else if (idx == REG_SCREEN_HEIGHT)
			scr_h = value;
	endtask

	task automatic configure_screen(input logic [9:0] w, input logic [9:0] h);
		settle_block();
		write_register(REG_SCREEN_WIDTH, w);
		write_register(REG_SCREEN_HEIGHT, h);
		// Writes to unmapped indexes must leave both registers alone.
		write_register($urandom_range(1) ? CFG_INDEX_SPARE2 : CFG_INDEX_SPARE3, 10'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Sends one well-formed glyph, sometimes cut short or followed by stray bytes.
	task automatic send_random_glyph(output int nbytes);
		int w, h, pick, sw, sh;
		glyph_item_t g;
		pick = $urandom_range(99);
		if (pick < 80) begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 12);
		end else if (pick < 92) begin
			w = $urandom_range(17, 255);
			h = $urandom_range(1, 2);
		end else if (pick[0]) begin
			w = 0;
			h = $urandom_range(0, 8);
		end else begin
			w = $urandom_range(1, 8);
			h = 0;
		end
		nbytes = (w * h + 7) / 8;
		if (nbytes > 40)
			nbytes = 40;
		if (nbytes == 0)
			nbytes = 1;
		pick = $urandom_range(9);
		if (pick == 0)
			nbytes = $urandom_range(1, nbytes);
		else if (pick == 1)
			nbytes = nbytes + $urandom_range(1, 3);
		sw = (scr_w > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_w);
		sh = (scr_h > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(scr_h);
		g = random_item();
		g.glyph_start = 1'b1;
		g.glyph_width = w[7:0];
		g.glyph_height = h[7:0];
		if ($urandom_range(3) != 0) begin
			g.origin_x = 16'($urandom_range(0, sw + 16));
			g.origin_y = 16'($urandom_range(0, sh + 16));
			g.offset_x = 8'($urandom_range(0, 16) - 8);
			g.offset_y = 8'($urandom_range(0, 16) - 8);
		end
		send_bitmap(g, nbytes);
	endtask

	task automatic test_reset_state();
		// No glyph has been started, so this byte must be ignored.
		send_glyph(filler_item(8'hFF));
		// Reset screen size: the run is cut at column 240.
		send_glyph(glyph_head(230, 310, 16, 1, 0, 0, 16'h1357, 8'hFF));
		send_glyph(filler_item(8'hFF));
	endtask

	task automatic test_directed_glyphs();
		send_glyph(glyph_head(10, 20, 8, 8, 0, 0, 16'hABCD, 8'hFF));
		send_glyph(filler_item(8'hAA));
		// One-pixel-wide glyph: every bit ends a row, eight runs from one byte.
		send_glyph(glyph_head(0, 0, 1, 8, 0, 0, 16'h1234, 8'hFF));
		// A run that spans a byte boundary, then bits past the end of the glyph.
		send_glyph(glyph_head(3, 5, 12, 1, 0, 0, 16'h00FF, 8'h0F));
		send_glyph(filler_item(8'hF0));
		send_glyph(filler_item(8'hFF));
		send_glyph(glyph_head(4, 4, 0, 5, 0, 0, 16'h2222, 8'hFF));
		send_glyph(glyph_head(4, 4, 5, 0, 0, 0, 16'h3333, 8'hFF));
		// Negative placement, directly and through 16-bit wrap.
		send_glyph(glyph_head(-32768, 0, 8, 1, -128, 0, 16'h4444, 8'hFF));
		send_glyph(glyph_head(32767, 0, 8, 1, 127, 0, 16'h5555, 8'hFF));
		send_glyph(glyph_head(0, 32767, 8, 1, 0, 127, 16'h5555, 8'hFF));
		send_glyph(glyph_head(-1, -1, 8, 2, 5, 3, 16'hFFFF, 8'hFF));
		send_glyph(filler_item(8'h81));
		send_glyph(glyph_head(235, 0, 16, 1, 0, 0, 16'h8001, 8'hFF));
		send_glyph(filler_item(8'hFF));
		send_glyph(glyph_head(0, 319, 8, 1, 0, 1, 16'h6666, 8'hFF));
		send_glyph(glyph_head(200, 100, 255, 255, -128, 127, 16'h5AA5, 8'hFF));
		send_glyph(filler_item(8'h00));
		send_glyph(filler_item(8'h7F));
		send_glyph(glyph_head(0, 0, 8, 1, 0, 0, 16'h0000, 8'h00));
	endtask

	task automatic test_screen_sizes();
		logic [9:0] widths [6];
		logic [9:0] heights [6];
		int sent;
		widths = '{10'd1, 10'd512, 10'd1023, 10'd0, 10'd97, 10'd240};
		heights = '{10'd1, 10'd512, 10'd1023, 10'd0, 10'd511, 10'd320};
		for (int k = 0; k < 6; k++) begin
			configure_screen(widths[k], heights[k]);
			send_glyph(glyph_head(0, 0, 4, 1, 0, 0, 16'h0F0F, 8'hF0));
			if (widths[k] == 10'd512) begin
				// Full-width row: a 255-pixel run on the bottom line.
				send_glyph(glyph_head(0, 511, 255, 1, 0, 0, 16'hF00F, 8'hFF));
				repeat (31) send_glyph(filler_item(8'hFF));
				send_glyph(glyph_head(500, 7, 16, 1, 0, 0, 16'hC3C3, 8'hFF));
				send_glyph(filler_item(8'hFF));
			end
			send_random_glyph(sent);
		end
	endtask

	task automatic test_sender_pause();
		int sent;
		send_random_glyph(sent);
		settle_block();
		send_random_glyph(sent);
		settle_block();
	endtask

	task automatic test_output_backpressure();
		hold_asks <= hold_asks + 1;
		repeat (3) send_bitmap(glyph_head(10, 10, 8, 8, 0, 0, 16'hBEEF, 8'hFF), 8);
	endtask

	task automatic test_random_glyphs();
		int sent, total, glyphs;
		total = 0;
		glyphs = 0;
		while (total < RANDOM_ITEMS) begin
			glyphs++;
			if (glyphs == 2) begin
				sender_idles <= 1'b0;
				stall_random <= 1'b0;
			end else if (glyphs == 6) begin
				sender_idles <= 1'b1;
				stall_random <= 1'b1;
			end else if (glyphs == 7) begin
				configure_screen(10'($urandom_range(16, 512)), 10'($urandom_range(16, 512)));
			end
			if ($urandom_range(9) == 0) begin
				send_glyph(random_item());
			end else begin
				send_random_glyph(sent);
				total += sent;
			end
		end
	endtask

	// Receiver: random stalls, or a long hold when a test asks for one.
	always @(posedge clk) begin
		if (hold_taken != hold_asks) begin
			hold_taken <= hold_asks;
			hold_left <= HOLD_CYCLES;
			run_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			run_stall <= 1'b1;
		end else begin
			run_stall <= stall_random && ($urandom_range(99) < 31);
		end
	end

	// Outputs are sampled mid-cycle; a run seen here is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && run_valid && !run_stall) begin
			if (expected_runs.size() == 0) begin
				$error("run with no expectation: x %0d y %0d length %0d",
					run.run_x, run.run_y, run.run_length);
				mismatches++;
			end else begin
				want = expected_runs.pop_front();
				check_field("run_x", 16'(want.run_x), 16'(run.run_x));
				check_field("run_y", 16'(want.run_y), 16'(run.run_y));
				check_field("run_length", 16'(want.run_length), 16'(run.run_length));
				check_field("swapped_colour", want.swapped_colour, run.swapped_colour);
				check_field("last_run", 16'(want.last_run), 16'(run.last_run));
			end
		end
	end

	always @(negedge clk) begin
		if ((glyph_valid && !glyph_stall) || (run_valid && !run_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_glyphs();
		test_screen_sizes();
		test_sender_pause();
		test_output_backpressure();
		test_random_glyphs();
		settle_block();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
